[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sete_pkg.sv]
// ----------------------------------------------------------------------------
// sete_pkg
// Types and constants shared by the sprite entry tile expander.
// ----------------------------------------------------------------------------
package sete_pkg;

	// Stream widths
	localparam int S_DATA_W = 48;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 48;

	// Depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_FLIP_SCREEN  = 1'b0;
	localparam logic REG_WIDE_VARIANT = 1'b1;

	// Narrow pass codes
	localparam logic [1:0] PASS_SET   = 2'd0;
	localparam logic [1:0] PASS_CLEAR = 2'd1;

	// Board geometry
	localparam logic signed [10:0] NARROW_OFFSET = 11'sd240;
	localparam logic signed [10:0] WIDE_OFFSET   = 11'sd304;
	localparam logic signed [10:0] NARROW_LIMIT  = 11'sd256;
	localparam logic signed [10:0] WIDE_LIMIT    = 11'sd320;
	localparam logic [8:0]         WIDE_WRAP_X   = 9'd320;

	typedef struct packed {
		logic flip_screen;
		logic wide_variant;
	} cfg_t;

	// One sprite, classified and ready for expansion
	typedef struct packed {
		logic [15:0] base;      // tile number with the height bits cleared
		logic [2:0]  mask;      // tile count minus one
		logic        code_up;   // entry Y flip: codes count with the step
		logic        mirror_x;
		logic        mirror_y;
		logic [4:0]  colour;
		logic [9:0]  pos_x;
		logic [9:0]  pos_y;     // position of the tile at step zero
		logic        step_up;   // tiles step down the screen
	} sprite_cmd_t;

	function automatic logic [2:0] height_mask(input logic [1:0] code);
		logic [2:0] m;
		case (code)
			2'd0: m = 3'd0;
			2'd1: m = 3'd1;
			2'd2: m = 3'd3;
			default: m = 3'd7;
		endcase
		return m;
	endfunction

endpackage

[rtl/sete_front.sv]
// ----------------------------------------------------------------------------
// sete_front
// Accepts sprite entries, drops hidden ones and builds expansion commands.
// ----------------------------------------------------------------------------
module sete_front (
	input  sete_pkg::cfg_t                       cfg,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// y_word[15:0], number_word[31:16], x_word[47:32]
	input  logic [sete_pkg::S_DATA_W-1:0]        s_tdata,
	// pass_select[1:0], frame_odd[2]
	input  logic [sete_pkg::S_USER_W-1:0]        s_tuser,
	input  logic                                 q_full,
	output logic                                 q_push,
	output sete_pkg::sprite_cmd_t                q_cmd
);
	import sete_pkg::*;

	logic [15:0]        y_word;
	logic [15:0]        number_word;
	logic [15:0]        x_word;
	logic [1:0]         pass_select;
	logic               frame_odd;
	logic               pass_ok;
	logic               off_screen;
	logic               emit;
	logic [2:0]         mask;
	logic signed [10:0] sx;
	logic signed [10:0] px;
	logic signed [10:0] py;
	logic signed [10:0] px_out;
	logic signed [10:0] py_out;

	assign y_word      = s_tdata[15:0];
	assign number_word = s_tdata[31:16];
	assign x_word      = s_tdata[47:32];
	assign pass_select = s_tuser[1:0];
	assign frame_odd   = s_tuser[2];

	always_comb begin
		if (cfg.wide_variant) begin
			pass_ok = (x_word[15:14] == pass_select);
		end else begin
			pass_ok = !((pass_select == PASS_CLEAR && x_word[14]) ||
				(pass_select == PASS_SET && !x_word[14]));
		end
	end

	// Wrap X and Y into signed range and place them on screen
	always_comb begin
		if (cfg.wide_variant) begin
			sx = (x_word[8:0] >= WIDE_WRAP_X) ? {2'b11, x_word[8:0]} : {2'b00, x_word[8:0]};
			px = WIDE_OFFSET - sx;
			off_screen = (px > WIDE_LIMIT);
		end else begin
			sx = {{2{x_word[8]}}, x_word[8:0]};
			px = NARROW_OFFSET - sx;
			off_screen = (px > NARROW_LIMIT);
		end
		py = NARROW_OFFSET - {{2{y_word[8]}}, y_word[8:0]};
		if (cfg.flip_screen) begin
			py_out = (cfg.wide_variant ? WIDE_OFFSET : NARROW_OFFSET) - py;
			px_out = NARROW_OFFSET - px;
		end else begin
			py_out = py;
			px_out = px;
		end
	end

	assign mask = height_mask(y_word[10:9]);

	assign emit = (number_word != 16'd0) && pass_ok && !(y_word[12] && frame_odd) &&
		!off_screen;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full && emit;

	always_comb begin
		q_cmd.base     = number_word & ~{13'd0, mask};
		q_cmd.mask     = mask;
		q_cmd.code_up  = y_word[14];
		q_cmd.mirror_x = y_word[13] ^ cfg.flip_screen;
		q_cmd.mirror_y = y_word[14] ^ cfg.flip_screen;
		q_cmd.colour   = cfg.wide_variant ? x_word[13:9] : {1'b0, x_word[12:9]};
		q_cmd.pos_x    = px_out[9:0];
		q_cmd.pos_y    = py_out[9:0];
		q_cmd.step_up  = cfg.flip_screen;
	end

endmodule

[rtl/sete_queue.sv]
// ----------------------------------------------------------------------------
// sete_queue
// Small command FIFO that decouples the front from the back (depth 2 and up).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sete_queue #(
	parameter int DEPTH = sete_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sete_pkg::sprite_cmd_t push_cmd,
	input  logic                  pop,
	output sete_pkg::sprite_cmd_t head_cmd,
	output logic                  empty,
	output logic                  full
);
	import sete_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sprite_cmd_t        slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign empty    = (count_q == CNT_W'(0));
	assign full     = (count_q == CNT_W'(DEPTH));
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`ASSERT_CLK(a_no_overflow, clk, arst_n, !(full && push && !pop), "push into full queue")
	`ASSERT_CLK(a_no_underflow, clk, arst_n, !(empty && pop), "pop from empty queue")
	`ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + CNT_W'(1), "count did not advance on push")

endmodule

[rtl/sete_back.sv]
// ----------------------------------------------------------------------------
// sete_back
// Expands one queued sprite command into its column of tile beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sete_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sete_pkg::sprite_cmd_t         head_cmd,
	input  logic                          q_empty,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tile_code[15:0], colour[20:16], mirror_x[21], mirror_y[22],
	// pos_x[32:23], pos_y[42:33], zero[47:43]
	output logic [sete_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast
);
	import sete_pkg::*;

	sprite_cmd_t cmd_q;
	logic        busy_q;
	logic [2:0]  step_q;
	logic        out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;
	logic        out_last_q;

	logic        advance;
	logic [2:0]  code_offset;
	logic [9:0]  delta_y;
	logic [9:0]  tile_y;
	logic [15:0] tile_code;

	// While a sprite is being expanded, a tile moves into the output register whenever that register frees up
	assign advance = busy_q && (!out_valid_q || m_tready);
	assign q_pop   = !q_empty && (!busy_q || (advance && step_q == 3'd0));

	assign code_offset = cmd_q.code_up ? step_q : cmd_q.mask - step_q;
	assign tile_code   = cmd_q.base | {13'd0, code_offset};
	assign delta_y     = {3'd0, step_q, 4'd0};
	assign tile_y      = cmd_q.step_up ? cmd_q.pos_y + delta_y : cmd_q.pos_y - delta_y;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= head_cmd;
		end
		if (advance) begin
			out_data_q <= {5'd0, tile_y, cmd_q.pos_x, cmd_q.mirror_y, cmd_q.mirror_x,
				cmd_q.colour, tile_code};
			out_last_q <= (step_q == 3'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				step_q <= head_cmd.mask;
			end else if (advance) begin
				if (step_q == 3'd0) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q - 3'd1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	`ASSERT_CLK(a_step_in_range, clk, arst_n, !busy_q || step_q <= cmd_q.mask, "tile step beyond sprite height")
	`ASSERT_NEXT(a_last_on_final, clk, arst_n, advance && step_q == 3'd0, m_tvalid && m_tlast, "final tile not marked last")

endmodule

[rtl/sprite_entry_tile_expander_top.sv]
// ----------------------------------------------------------------------------
// sprite_entry_tile_expander_top
// Sprite attribute entry to 16x16 tile draw command expander.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat
// s_*       in         one sprite entry (three words, pass select, frame parity)
// m_*       out        one tile draw command, tlast on the final tile of a sprite
// APB       in/out     flip_screen at 0x0, wide_variant at 0x4
//
// An entry is classified in the cycle it is accepted and queued; a hidden
// entry is accepted and gives no beat. The back part emits one tile per
// cycle while m_tready is high, 1, 2, 4 or 8 per sprite, on m_*; the
// output register sets that rate. Input is taken while the command queue
// has room, independent of m_tready. Reset clears both registers to 0 and
// empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sprite_entry_tile_expander_top #(
	parameter int QUEUE_DEPTH = sete_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sete_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sete_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sete_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	// Sprite entries
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// y_word[15:0], number_word[31:16], x_word[47:32]
	input  logic [sete_pkg::S_DATA_W-1:0]   s_tdata,
	// pass_select[1:0], frame_odd[2]
	input  logic [sete_pkg::S_USER_W-1:0]   s_tuser,
	// Tile commands
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tile_code[15:0], colour[20:16], mirror_x[21], mirror_y[22],
	// pos_x[32:23], pos_y[42:33], zero[47:43]
	output logic [sete_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                            m_tlast
);
	import sete_pkg::*;

	cfg_t        cfg_q;
	logic        reg_sel;
	logic        wr_en;
	logic        q_push;
	logic        q_pop;
	logic        q_empty;
	logic        q_full;
	sprite_cmd_t push_cmd;
	sprite_cmd_t head_cmd;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_FLIP_SCREEN:  cfg_q.flip_screen  <= pwdata[0];
				REG_WIDE_VARIANT: cfg_q.wide_variant <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_FLIP_SCREEN:  prdata = {31'd0, cfg_q.flip_screen};
			REG_WIDE_VARIANT: prdata = {31'd0, cfg_q.wide_variant};
			default:          prdata = '0;
		endcase
	end

	sete_front u_front (
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	sete_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	sete_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sprite entry tile expander.
// Sprite entries are streamed in, and each one is expanded into the tile
// commands it should draw. Every tile beat is compared with the oldest
// command still due. Both stream sides idle at random outside one phase.
// The board registers are rewritten over the APB port between phases,
// only once the block has gone quiet.
// ----------------------------------------------------------------------------
module testbench;
	import sete_pkg::*;

	localparam int SETTLE      = 40;
	localparam int QUIET_LIMIT = 2000;
	localparam int RAND_ITEMS  = 32;
	localparam int PHASES      = 5;

	localparam logic [APB_ADDR_W-1:0] ADDR_FLIP = {REG_FLIP_SCREEN, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_WIDE = {REG_WIDE_VARIANT, 2'b00};

	typedef struct {
		logic [15:0] y_word;
		logic [15:0] number_word;
		logic [15:0] x_word;
		logic [1:0]  pass_select;
		logic        frame_odd;
		bit          drain;       // hold this entry until every tile is out
	} sprite_entry_t;

	typedef struct {
		logic [15:0] tile_code;
		logic [4:0]  colour;
		logic        mirror_x;
		logic        mirror_y;
		logic [9:0]  pos_x;
		logic [9:0]  pos_y;
		logic        last;
	} tile_cmd_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata  = '0;
	logic [S_USER_W-1:0]   s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;

	sprite_entry_t pending[$];
	tile_cmd_t     tiles_due[$];
	sprite_entry_t shown;
	bit            entry_busy   = 1'b0;
	bit            no_idle      = 1'b0;
	bit            cfg_flip     = 1'b0;
	bit            cfg_wide     = 1'b0;
	int            src_wait     = 0;
	int            sink_wait    = 0;
	int            fails        = 0;
	int            quiet_cycles = 0;

	sprite_entry_tile_expander_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Work out the tile column one entry should draw under the current registers.
	function automatic void expand_entry(input sprite_entry_t e);
		int        tiles, mask, sx, sy, px, py, step, k;
		logic [15:0] base;
		logic [4:0]  colour;
		logic        fx, fy;
		tile_cmd_t   t;
		if (e.number_word == 16'd0)
			return;
		if (cfg_wide) begin
			if (e.x_word[15:14] != e.pass_select)
				return;
		end else begin
			if (e.pass_select == PASS_CLEAR && e.x_word[14])
				return;
			if (e.pass_select == PASS_SET && !e.x_word[14])
				return;
		end
		if (e.y_word[12] && e.frame_odd)
			return;
		colour = cfg_wide ? e.x_word[13:9] : {1'b0, e.x_word[12:9]};
		fx = e.y_word[13];
		fy = e.y_word[14];
		tiles = 1 << e.y_word[10:9];
		mask = tiles - 1;
		sx = int'(e.x_word[8:0]);
		sy = int'(e.y_word[8:0]);
		if (sy >= 256)
			sy -= 512;
		if (cfg_wide) begin
			if (sx >= int'(WIDE_WRAP_X))
				sx -= 512;
			px = int'(WIDE_OFFSET) - sx;
			if (px > int'(WIDE_LIMIT))
				return;
		end else begin
			if (sx >= 256)
				sx -= 512;
			px = int'(NARROW_OFFSET) - sx;
			if (px > int'(NARROW_LIMIT))
				return;
		end
		py = int'(NARROW_OFFSET) - sy;
		base = e.number_word & ~16'(mask);
		if (cfg_flip) begin
			py = (cfg_wide ? int'(WIDE_OFFSET) : int'(NARROW_OFFSET)) - py;
			px = int'(NARROW_OFFSET) - px;
			step = 16;
		end else begin
			step = -16;
		end
		for (k = mask; k >= 0; k--) begin
			t.tile_code = fy ? base + 16'(k) : base + 16'(mask - k);
			t.colour    = colour;
			t.mirror_x  = fx ^ cfg_flip;
			t.mirror_y  = fy ^ cfg_flip;
			t.pos_x     = 10'(px);
			t.pos_y     = 10'(py + step * k);
			t.last      = (k == 0);
			tiles_due.push_back(t);
		end
	endfunction

	function automatic sprite_entry_t make_entry(input logic [15:0] yw, input logic [15:0] num,
			input logic [15:0] xw, input logic [1:0] pass, input logic odd);
		sprite_entry_t e;
		e.y_word      = yw;
		e.number_word = num;
		e.x_word      = xw;
		e.pass_select = pass;
		e.frame_odd   = odd;
		e.drain       = 1'b0;
		return e;
	endfunction

	// Mostly entries that get drawn, with random content; the rest is raw noise.
	function automatic sprite_entry_t rand_entry();
		sprite_entry_t e;
		int            x, span, lim;
		e = make_entry(16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
			1'($urandom));
		if ($urandom_range(0, 99) < 75) begin
			if (e.number_word == 16'd0)
				e.number_word = 16'd1;
			if (e.y_word[12])
				e.frame_odd = 1'b0;
			if (cfg_wide)
				e.pass_select = e.x_word[15:14];
			else if (!e.pass_select[1])
				e.pass_select = e.x_word[14] ? PASS_SET : PASS_CLEAR;
			lim = cfg_wide ? int'(WIDE_LIMIT) : int'(NARROW_LIMIT);
			span = lim + 15;
			x = $urandom_range(0, span);
			if (x >= lim)
				x = x - lim + 496;
			e.x_word[8:0] = 9'(x);
		end
		return e;
	endfunction

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {31'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending.size() != 0 || entry_busy || tiles_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	// Entry driver
	always @(posedge clk) begin : driver
		bit take;
		if (arst_n) begin
			take = !s_tvalid;
			if (s_tvalid && s_tready) begin
				expand_entry(shown);
				entry_busy = 1'b0;
				take = 1'b1;
			end
			if (take) begin
				if (src_wait > 0) begin
					src_wait--;
					s_tvalid <= 1'b0;
				end else if (pending.size() != 0 &&
						!(pending[0].drain && tiles_due.size() != 0)) begin
					shown = pending.pop_front();
					entry_busy = 1'b1;
					s_tdata  <= {shown.x_word, shown.number_word, shown.y_word};
					s_tuser  <= {shown.frame_odd, shown.pass_select};
					s_tvalid <= 1'b1;
					src_wait = no_idle ? 0 : $urandom_range(0, 14);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Tile monitor
	always @(posedge clk) begin : monitor
		tile_cmd_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (tiles_due.size() == 0) begin
					$error("tile beat with no command due: code %0h", m_tdata[15:0]);
					fails++;
				end else begin
					want = tiles_due.pop_front();
					check_field("tile_code", want.tile_code, m_tdata[15:0]);
					check_field("colour", 16'(want.colour), 16'(m_tdata[20:16]));
					check_field("mirror_x", 16'(want.mirror_x), 16'(m_tdata[21]));
					check_field("mirror_y", 16'(want.mirror_y), 16'(m_tdata[22]));
					check_field("pos_x", 16'(want.pos_x), 16'(m_tdata[32:23]));
					check_field("pos_y", 16'(want.pos_y), 16'(m_tdata[42:33]));
					check_field("pad", 16'd0, 16'(m_tdata[47:43]));
					check_field("last", 16'(want.last), 16'(m_tlast));
				end
				sink_wait = no_idle ? 0 : $urandom_range(0, 14);
			end else if (sink_wait > 0 && m_tvalid) begin
				sink_wait--;
			end
			m_tready <= (sink_wait == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(psel && penable && pready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("testbench NOT OK");
		$finish;
	end

	initial begin : stimulus
		bit flips[PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
		bit wides[PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
		int ph, i, drain_at;
		sprite_entry_t e;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			apb_write(ADDR_FLIP, flips[ph]);
			cfg_flip = flips[ph];
			apb_write(ADDR_WIDE, wides[ph]);
			cfg_wide = wides[ph];
			no_idle = (ph == 2);
			if (ph == 0) begin
				// narrow board
				pending.push_back(make_entry(16'h0000, 16'h0000, 16'h0000, 2'd0, 1'b0));
				pending.push_back(make_entry(16'hffff, 16'hffff, 16'hffff, 2'd3, 1'b1));
				pending.push_back(make_entry(16'hffff, 16'hffff, 16'hffff, 2'd3, 1'b0));
				pending.push_back(make_entry(16'h0010, 16'h0005, 16'h4664, PASS_SET, 1'b0));
				pending.push_back(make_entry(16'h0232, 16'h1235, 16'h4a10, PASS_SET, 1'b0));
				pending.push_back(make_entry(16'h44c8, 16'h00ff, 16'h0280, PASS_CLEAR, 1'b0));
				pending.push_back(make_entry(16'h272c, 16'h8001, 16'h1e20, PASS_CLEAR, 1'b0));
				// wrong pass either way
				pending.push_back(make_entry(16'h0040, 16'h0010, 16'h0040, PASS_SET, 1'b0));
				pending.push_back(make_entry(16'h0040, 16'h0010, 16'h4040, PASS_CLEAR, 1'b0));
				// pass two draws regardless of bit 14
				pending.push_back(make_entry(16'h0240, 16'h0011, 16'h0040, 2'd2, 1'b0));
				// flashing: hidden on odd frames only
				pending.push_back(make_entry(16'h1040, 16'h0012, 16'h4040, PASS_SET, 1'b1));
				pending.push_back(make_entry(16'h1040, 16'h0012, 16'h4040, PASS_SET, 1'b0));
				// off-screen edge and the last column still drawn
				pending.push_back(make_entry(16'h0040, 16'h0013, 16'h412c, PASS_SET, 1'b0));
				pending.push_back(make_entry(16'h0040, 16'h0013, 16'h41ef, PASS_SET, 1'b0));
				pending.push_back(make_entry(16'h0040, 16'h0013, 16'h41f0, PASS_SET, 1'b0));
				pending.push_back(make_entry(16'h0040, 16'h0013, 16'h4100, PASS_SET, 1'b0));
			end else if (ph == 1) begin
				// wide board
				pending.push_back(make_entry(16'h0040, 16'h0020, 16'h8040, 2'd1, 1'b0));
				pending.push_back(make_entry(16'h0040, 16'h0021, 16'hfe00 | 16'h013f,
						2'd3, 1'b0));
				pending.push_back(make_entry(16'h0040, 16'h0022, 16'h0140, 2'd0, 1'b0));
				pending.push_back(make_entry(16'h0040, 16'h0022, 16'h01ef, 2'd0, 1'b0));
				pending.push_back(make_entry(16'h0040, 16'h0022, 16'h01f0, 2'd0, 1'b0));
				pending.push_back(make_entry(16'h6680, 16'h7777, 16'h6a30, 2'd1, 1'b1));
			end
			drain_at = $urandom_range(5, RAND_ITEMS - 5);
			for (i = 0; i < RAND_ITEMS; i++) begin
				e = rand_entry();
				e.drain = (i == drain_at);
				pending.push_back(e);
			end
		end
		wait_idle();
		if (fails == 0 && tiles_due.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[sprite_entry_tile_expander_top.f]
+incdir+rtl
rtl/sete_pkg.sv
rtl/sete_front.sv
rtl/sete_queue.sv
rtl/sete_back.sv
rtl/sprite_entry_tile_expander_top.sv
bench/testbench.sv
